@@ rtl/tcw_pkg.sv @@
// Shared types, codes and defaults for the text console writer.
`default_nettype none

package tcw_pkg;

    // Default geometry
    localparam int COLUMNS_DEF   = 80;
    localparam int ROWS_DEF      = 25;
    localparam int TAB_WIDTH_DEF = 8;

    // Character codes
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] TAB_CODE     = 8'd9;

    // Item function codes
    typedef enum logic [1:0] {
        FN_PUT   = 2'd0,
        FN_READ  = 2'd1,
        FN_CLEAR = 2'd2
    } t_func;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUT,
        ST_READ,
        ST_COPY,
        ST_FILL,
        ST_DONE
    } t_state;

    // What a space fill is for
    typedef enum logic [1:0] {
        FK_BOOT,
        FK_CLEAR,
        FK_SCROLL
    } t_fill_kind;

    // Input transfer
    typedef struct packed {
        t_func      func;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_in;

    // Output transfer
    typedef struct packed {
        logic [7:0] cell_char;
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic       did_scroll;
    } t_out;

endpackage

`default_nettype wire

@@ rtl/tcw_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module tcw_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 2000,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/text_console_writer_unit.sv @@
// Character-cell console: screen store in RAM, cursor, newline/tab, scroll-up.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_data  (tcw_pkg::t_in)
//  out     | output    | o_out_valid / i_out_stall  | o_out_data (tcw_pkg::t_out)
//
// Put without scroll and read pass through ST_PUT or ST_READ; an unused code is answered from ST_IDLE.
// Clear sweeps the store one cell a cycle.
// A put on a pending scroll copies COLUMNS*(ROWS-1) cells through the RAM
// read port, then blanks the last row before the put itself.
// After reset a space fill of all COLUMNS*ROWS cells runs with o_in_stall high.
// One item is in flight at a time; a new one is taken while a result waits in the output register.
`default_nettype none

module text_console_writer_unit #(
    parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS      = tcw_pkg::ROWS_DEF,
    parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_in_valid,
    output logic        o_in_stall,
    input  wire tcw_pkg::t_in i_in_data,
    output logic        o_out_valid,
    input  wire logic   i_out_stall,
    output tcw_pkg::t_out o_out_data
);

    import tcw_pkg::*;

    localparam int TOTAL  = COLUMNS * ROWS;
    localparam int COPY_N = COLUMNS * (ROWS - 1);
    localparam int AW     = $clog2(TOTAL);
    localparam int PW     = $clog2(TOTAL + 1);
    localparam int RW     = $clog2(ROWS + 1);
    localparam int CW     = $clog2(COLUMNS);
    localparam int XW     = $clog2(COLUMNS + TAB_WIDTH);
    localparam int TPW    = $clog2(TAB_WIDTH);

    t_state     r_state, n_state;
    t_fill_kind r_kind, n_kind;
    logic [PW-1:0]  r_ptr, n_ptr;
    logic [RW-1:0]  r_row, n_row;
    logic [CW-1:0]  r_col, n_col;
    logic [TPW-1:0] r_phase, n_phase;
    logic [7:0]     r_code, n_code;
    logic           r_scrolled, n_scrolled;
    logic           r_rd_ok, n_rd_ok;
    t_out           r_res, n_res;
    t_out           r_out, n_out;
    logic           r_out_valid, n_out_valid;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    logic          accept, out_free, fin, rd_in_bounds;
    t_out          res;
    logic [XW-1:0] col_x;
    logic          wrap;
    logic [TPW-1:0] phase_inc;

    tcw_ram #(
        .WIDTH (8),
        .DEPTH (TOTAL)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign accept      = i_in_valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign rd_in_bounds = (32'(i_in_data.read_row) < ROWS)
                       && (32'(i_in_data.read_col) < COLUMNS);

    // Column after a tab or a printed character, before wrap
    always_comb begin
        if (r_code == TAB_CODE) begin
            col_x = XW'(r_col) + XW'(TAB_WIDTH) - XW'(r_phase);
        end else begin
            col_x = XW'(r_col) + XW'(1);
        end
        wrap      = (col_x >= XW'(COLUMNS));
        phase_inc = (r_phase == TPW'(TAB_WIDTH - 1)) ? '0 : r_phase + TPW'(1);
    end

    // Next state, RAM control and result
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_ptr       = r_ptr;
        n_row       = r_row;
        n_col       = r_col;
        n_phase     = r_phase;
        n_code      = r_code;
        n_scrolled  = r_scrolled;
        n_rd_ok     = r_rd_ok;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = SPACE_CODE;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        fin         = 1'b0;
        res         = '0;

        // Output register drains on transfer
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_in_data.func)
                        FN_PUT: begin
                            n_code     = i_in_data.char_code;
                            n_scrolled = 1'b0;
                            n_ptr      = '0;
                            if (32'(r_row) >= ROWS) begin
                                n_state = ST_COPY;
                            end else begin
                                n_state = ST_PUT;
                            end
                        end
                        FN_READ: begin
                            n_rd_ok   = rd_in_bounds;
                            ram_re    = rd_in_bounds;
                            ram_raddr = AW'(32'(i_in_data.read_row) * COLUMNS
                                            + 32'(i_in_data.read_col));
                            n_state   = ST_READ;
                        end
                        FN_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_phase = '0;
                            n_ptr   = '0;
                            n_kind  = FK_CLEAR;
                            n_state = ST_FILL;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            ST_PUT: begin
                if (r_code == NEWLINE_CODE) begin
                    n_col   = '0;
                    n_row   = RW'(r_row + 1'b1);
                    n_phase = '0;
                end else begin
                    if (r_code != TAB_CODE) begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(32'(r_row) * COLUMNS + 32'(r_col));
                        ram_wdata = r_code;
                        n_phase   = phase_inc;
                    end else begin
                        n_phase = '0;
                    end
                    if (wrap) begin
                        n_col   = '0;
                        n_row   = RW'(r_row + 1'b1);
                        n_phase = '0;
                    end else begin
                        n_col = CW'(col_x);
                    end
                end
                res.did_scroll = r_scrolled;
                fin            = 1'b1;
            end

            ST_READ: begin
                res.cell_char = r_rd_ok ? ram_rdata : 8'd0;
                fin           = 1'b1;
            end

            // Move rows up: read cell k+COLUMNS, write it to k in the following cycle
            ST_COPY: begin
                if (r_ptr != PW'(COPY_N)) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_ptr + PW'(COLUMNS));
                end
                if (r_ptr != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(r_ptr - PW'(1));
                    ram_wdata = ram_rdata;
                end
                if (r_ptr == PW'(COPY_N)) begin
                    n_kind  = FK_SCROLL;
                    n_state = ST_FILL;
                end else begin
                    n_ptr = r_ptr + PW'(1);
                end
            end

            // Space fill from r_ptr to the end of the store
            ST_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr[AW-1:0];
                ram_wdata = SPACE_CODE;
                if (r_ptr == PW'(TOTAL - 1)) begin
                    case (r_kind)
                        FK_SCROLL: begin
                            n_row      = RW'(ROWS - 1);
                            n_scrolled = 1'b1;
                            n_state    = ST_PUT;
                        end
                        FK_CLEAR: begin
                            fin = 1'b1;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end else begin
                    n_ptr = r_ptr + PW'(1);
                end
            end

            ST_DONE: begin
                res = r_res;
                fin = 1'b1;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Hand the result to the output register, or park it
        if (fin) begin
            if (r_state != ST_DONE) begin
                res.cursor_col = 7'(n_col);
                res.cursor_row = 5'(n_row);
            end
            if (out_free) begin
                n_out       = res;
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end else begin
                n_res   = res;
                n_state = ST_DONE;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_kind      <= FK_BOOT;
            r_ptr       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_phase     <= '0;
            r_scrolled  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_ptr       <= n_ptr;
            r_row       <= n_row;
            r_col       <= n_col;
            r_phase     <= n_phase;
            r_scrolled  <= n_scrolled;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_code  <= n_code;
        r_rd_ok <= n_rd_ok;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // The read data of a read item must not be disturbed by a write
    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !ram_we)
        else $error("screen write during read item");

    // Cursor stays on screen, or one row below it when a scroll is pending
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (32'(r_col) < COLUMNS && 32'(r_row) <= ROWS))
        else $error("cursor out of range");

    // Scroll copy always writes at a lower address than the cell it is reading
    a_copy_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY && ram_we && ram_re) |-> (ram_waddr < ram_raddr))
        else $error("scroll copy overtakes its reads");

endmodule

`default_nettype wire

@@ test/tb_text_console_writer_unit.sv @@
// Self-checking testbench for text_console_writer_unit: screen, cursor and scroll checks.
`timescale 1ns / 1ps

module tb_text_console_writer_unit;
    import tcw_pkg::*;

    localparam int SCREEN_COLS  = COLUMNS_DEF;
    localparam int SCREEN_ROWS  = ROWS_DEF;
    localparam int TAB_STOP     = TAB_WIDTH_DEF;
    localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;

    // Function code the block leaves undefined; it must change nothing
    localparam logic [1:0] FN_RESERVED = 2'd3;

    // Random traffic size and idling phase boundaries (in commands), hold length (in cycles)
    localparam int RANDOM_COMMANDS = 1000;
    localparam int PHASE_TWO_AT    = 380;
    localparam int PHASE_THREE_AT  = 700;
    localparam int HOLD_AT         = 200;
    localparam int DRAIN_AT        = 520;
    localparam int HOLD_CYCLES     = 400;

    // Worst case: every command a full scroll or clear behind stalls
    localparam int CYCLE_LIMIT = 10_000_000;

    // Screen predictor and queue of replies still owed by the block
    class screen_scoreboard;
        logic [7:0]  cells [SCREEN_CELLS];
        int unsigned col;
        int unsigned row;
        t_out        replies_due [$];
        int          mismatches;

        function new();
            blank();
            col        = 0;
            row        = 0;
            mismatches = 0;
        endfunction

        function void blank();
            foreach (cells[i]) cells[i] = SPACE_CODE;
        endfunction

        // Advance the screen model by one accepted command and queue its reply
        function void note_command(t_in cmd);
            t_out reply;
            int   i;
            reply = '0;
            case (cmd.func)
                FN_PUT: begin
                    // pending scroll: shift rows up, blank the last one
                    if (row >= SCREEN_ROWS) begin
                        for (i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++)
                            cells[i] = cells[i + SCREEN_COLS];
                        for (i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
                            cells[i] = SPACE_CODE;
                        row = SCREEN_ROWS - 1;
                        reply.did_scroll = 1'b1;
                    end
                    if (cmd.char_code == NEWLINE_CODE) begin
                        col = 0;
                        row++;
                    end else if (cmd.char_code == TAB_CODE) begin
                        col = col - col % TAB_STOP + TAB_STOP;
                    end else begin
                        if (row < SCREEN_ROWS && col < SCREEN_COLS)
                            cells[row * SCREEN_COLS + col] = cmd.char_code;
                        col++;
                    end
                    // right edge wraps to the next row
                    if (col >= SCREEN_COLS) begin
                        col = 0;
                        row++;
                    end
                end
                FN_READ: begin
                    if (cmd.read_row < SCREEN_ROWS && cmd.read_col < SCREEN_COLS)
                        reply.cell_char = cells[cmd.read_row * SCREEN_COLS + cmd.read_col];
                end
                FN_CLEAR: begin
                    blank();
                    col = 0;
                    row = 0;
                end
                default: ;
            endcase
            reply.cursor_col = col[6:0];
            reply.cursor_row = row[4:0];
            replies_due.push_back(reply);
        endfunction

        // Compare one reply transfer against the oldest owed reply
        function void check_reply(t_out got);
            t_out want;
            if (replies_due.size() == 0) begin
                $error("reply with no command outstanding: %p", got);
                mismatches++;
                return;
            end
            want = replies_due.pop_front();
            if (got.cell_char !== want.cell_char) begin
                $error("cell_char: expected %0d, got %0d", want.cell_char, got.cell_char);
                mismatches++;
            end
            if (got.cursor_col !== want.cursor_col) begin
                $error("cursor_col: expected %0d, got %0d", want.cursor_col, got.cursor_col);
                mismatches++;
            end
            if (got.cursor_row !== want.cursor_row) begin
                $error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
                mismatches++;
            end
            if (got.did_scroll !== want.did_scroll) begin
                $error("did_scroll: expected %0d, got %0d", want.did_scroll, got.did_scroll);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return replies_due.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    screen_scoreboard board;
    int commands_sent  = 0;
    int send_gap_pct   = 9;
    int recv_stall_pct = 55;
    bit hold_request   = 1'b0;
    int cycle_count;

    text_console_writer_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Offer one command, hold it until the transfer, then predict its reply
    task automatic send_command(input logic [1:0] fn, input logic [7:0] code,
                                input logic [4:0] rrow, input logic [6:0] rcol);
        t_in cmd;
        cmd.func      = t_func'(fn);
        cmd.char_code = code;
        cmd.read_row  = rrow;
        cmd.read_col  = rcol;
        while ($urandom_range(99) < send_gap_pct)
            @(negedge i_clk) i_in_valid <= 1'b0;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= cmd;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        board.note_command(cmd);
        if (fn != FN_RESERVED)
            commands_sent++;
    endtask

    task automatic put_char(input logic [7:0] code);
        send_command(FN_PUT, code, 5'($urandom_range(31)), 7'($urandom_range(127)));
    endtask

    task automatic read_cell(input logic [4:0] rrow, input logic [6:0] rcol);
        send_command(FN_READ, 8'($urandom_range(255)), rrow, rcol);
    endtask

    task automatic clear_screen();
        send_command(FN_CLEAR, 8'($urandom_range(255)), 5'($urandom_range(31)),
                     7'($urandom_range(127)));
    endtask

    // Withdraw the last offered command, then wait for every owed reply
    task automatic wait_all_replies();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    // One random burst: text lines, newline runs, tab runs, reads, clear or noise
    task automatic send_random_burst();
        int kind;
        int count;
        kind = $urandom_range(99);
        if (kind < 45) begin
            count = ($urandom_range(9) == 0) ? $urandom_range(170, 81) : $urandom_range(60, 1);
            repeat (count) put_char(8'($urandom_range(255)));
            if ($urandom_range(4) != 0) put_char(NEWLINE_CODE);
        end else if (kind < 60) begin
            repeat ($urandom_range(8, 1)) put_char(NEWLINE_CODE);
        end else if (kind < 68) begin
            repeat ($urandom_range(12, 1))
                put_char(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : TAB_CODE);
        end else if (kind < 88) begin
            repeat ($urandom_range(6, 1)) begin
                if ($urandom_range(6) == 0)
                    read_cell(5'($urandom_range(31)), 7'($urandom_range(127)));
                else
                    read_cell(5'($urandom_range(24)), 7'($urandom_range(79)));
            end
        end else if (kind < 91) begin
            clear_screen();
        end else begin
            repeat ($urandom_range(4, 1))
                send_command(2'($urandom_range(3)), 8'($urandom_range(255)),
                             5'($urandom_range(31)), 7'($urandom_range(127)));
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Reply monitor
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
                board.check_reply(o_out_data);
        end
    end

    // Run guard
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_text_console_writer_unit: done, errors");
        $finish;
    end

    // Stimulus
    initial begin
        bit hold_done;
        bit drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        board      = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed: byte extremes, tab, newline, edge reads, reserved code
        read_cell(5'd0, 7'd0);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(TAB_CODE);
        put_char(8'h41);
        put_char(NEWLINE_CODE);
        read_cell(5'd0, 7'd0);
        read_cell(5'd0, 7'd1);
        read_cell(5'd0, 7'd8);
        read_cell(5'd24, 7'd79);
        read_cell(5'd25, 7'd0);
        read_cell(5'd0, 7'd80);
        read_cell(5'd31, 7'd127);
        send_command(FN_RESERVED, 8'hFF, 5'd31, 7'd127);
        // tab run; the last one crosses the right edge and wraps
        repeat (10) put_char(TAB_CODE);
        clear_screen();

        // random bursts across three idling phases
        while (commands_sent < RANDOM_COMMANDS) begin
            if (commands_sent >= PHASE_THREE_AT) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end else if (commands_sent >= PHASE_TWO_AT) begin
                send_gap_pct   = 55;
                recv_stall_pct = 9;
            end
            // long receiver hold-off while commands keep coming
            if (!hold_done && commands_sent >= HOLD_AT) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            // sender pause until the block has drained
            if (!drain_done && commands_sent >= DRAIN_AT) begin
                wait_all_replies();
                drain_done = 1'b1;
            end
            send_random_burst();
        end
        @(negedge i_clk) i_in_valid <= 1'b0;

        wait_all_replies();
        repeat (20) @(posedge i_clk);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("tb_text_console_writer_unit: done, clean");
        else
            $display("tb_text_console_writer_unit: done, errors");
        $finish;
    end

endmodule
